// ===== hw/rtl/stib_pkg.sv =====
// ----------------------------------------------------------------------------
// stib_pkg - shared types and constants for the sorted word list indexer
// Result beat layout, result kinds, error codes and ASCII helpers.
// ----------------------------------------------------------------------------
package stib_pkg;

  localparam int OUT_TDATA_W = 88;

  localparam logic [1:0] KIND_WORD_BYTE = 2'd0;
  localparam logic [1:0] KIND_ENTRY     = 2'd1;
  localparam logic [1:0] KIND_DONE      = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_MISSING_TAB = 2'd1;
  localparam logic [1:0] ERR_SORT_ORDER  = 2'd2;
  localparam logic [1:0] ERR_EMPTY       = 2'd3;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [31:0] entry_count;
    logic [4:0]  word_length;
    logic [31:0] line_offset;
    logic [4:0]  char_position;
    logic [7:0]  word_byte;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] f;
    f = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      f = b + 8'h20;
    end
    return f;
  endfunction

endpackage

// ===== hw/rtl/stib_word_mem.sv =====
// ----------------------------------------------------------------------------
// stib_word_mem - stored word memory
// Single port, registered read, read-first on a write to the same entry.
// ----------------------------------------------------------------------------
module stib_word_mem #(
  parameter int DEPTH = 31,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:DEPTH-1];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/stib_out_buf.sv =====
// ----------------------------------------------------------------------------
// stib_out_buf - result output register with skid stage
// Holds up to two result beats so the input side keeps moving under stalls.
// ----------------------------------------------------------------------------
module stib_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stib_pkg::result_t push_data,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output stib_pkg::result_t out_data
);

  stib_pkg::result_t out_r;
  stib_pkg::result_t skid_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              pop;

  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r       <= push_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign ready     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/sorted_tsv_index_builder.sv =====
// ----------------------------------------------------------------------------
// sorted_tsv_index_builder - one-pass index builder for a sorted word list
// Parses tab-separated lines byte by byte, streams each word, checks the
// case-insensitive sort order against the stored previous word and reports
// one entry per line, then a final status at end of file if no error came first.
//
//   port group | dir | tdata                 | tuser / tlast
//   in_        | in  | data_byte             | tlast: end_of_file
//   out_       | out | word_byte, char_pos,  | tuser: result_kind
//              |     | line_offset, word_len,|
//              |     | entry_count, err_code |
//
// One input beat per cycle while the output buffer has room. Each word byte reads its stored
// counterpart from the registered word memory read port; the compare result
// is forwarded into the next beat's order decision.
// Synchronous reset clears all control state; the word memory is not cleared.
// Output stalls are absorbed by a two-beat output buffer; in_tready drops
// only while both of its beats are held.
// ----------------------------------------------------------------------------
module sorted_tsv_index_builder #(
  parameter int WORD_MAX   = 32,
  parameter int LINE_LIMIT = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [stib_pkg::OUT_TDATA_W-1:0] out_tdata,  // word_byte, char_position,
                                                       // line_offset, word_length,
                                                       // entry_count, error_code
  output logic [1:0]                       out_tuser   // [1:0] result_kind
);

  localparam int DEPTH = WORD_MAX - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(WORD_MAX);
  localparam int CW    = $clog2(LINE_LIMIT);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_WORD  = 2'd1;
  localparam logic [1:0] PH_REST  = 2'd2;
  localparam logic [1:0] PH_ERROR = 2'd3;

  localparam logic [1:0] ORD_EQUAL   = 2'd0;
  localparam logic [1:0] ORD_GREATER = 2'd1;
  localparam logic [1:0] ORD_LESS    = 2'd2;

  logic [1:0]    phase_r,    phase_nxt;
  logic          cr_r,       cr_nxt;
  logic [1:0]    order_r,    order_nxt;
  logic          pend_r,     pend_nxt;
  logic [7:0]    pend_c_r,   pend_c_nxt;
  logic [31:0]   pos_r,      pos_nxt;
  logic [31:0]   lstart_r,   lstart_nxt;
  logic [31:0]   entries_r,  entries_nxt;
  logic [LW-1:0] prev_len_r, prev_len_nxt;
  logic [LW-1:0] cur_len_r,  cur_len_nxt;
  logic [CW-1:0] lchars_r,   lchars_nxt;

  logic              in_beat;
  logic              mem_en;
  logic [AW-1:0]     mem_addr;
  logic [7:0]        mem_rd;
  logic [7:0]        stored_c;
  logic [1:0]        order_eff;
  logic              res_vld;
  stib_pkg::result_t res;
  stib_pkg::result_t out_res;
  logic              buf_ready;

  assign in_tready = buf_ready;
  assign in_beat   = in_tvalid && buf_ready;
  assign stored_c  = stib_pkg::fold_case(mem_rd);

  always_comb begin
    order_eff = order_r;
    if (pend_r && order_r == ORD_EQUAL) begin
      if (pend_c_r < stored_c) begin
        order_eff = ORD_LESS;
      end else if (pend_c_r > stored_c) begin
        order_eff = ORD_GREATER;
      end
    end
  end

  always_comb begin
    logic [7:0]    b;
    logic [LW-1:0] clen;
    logic [CW-1:0] lchars;
    logic [1:0]    ord;
    b            = in_tdata;
    clen         = cur_len_r;
    lchars       = lchars_r;
    ord          = order_eff;
    phase_nxt    = phase_r;
    cr_nxt       = cr_r;
    order_nxt    = order_eff;
    pend_nxt     = 1'b0;
    pend_c_nxt   = pend_c_r;
    pos_nxt      = pos_r;
    lstart_nxt   = lstart_r;
    entries_nxt  = entries_r;
    prev_len_nxt = prev_len_r;
    cur_len_nxt  = cur_len_r;
    lchars_nxt   = lchars_r;
    mem_en       = 1'b0;
    mem_addr     = AW'(cur_len_r);
    res_vld      = 1'b0;
    res          = '0;
    if (in_beat) begin
      if (in_tlast) begin
        phase_nxt    = PH_START;
        cr_nxt       = 1'b0;
        order_nxt    = ORD_EQUAL;
        pos_nxt      = '0;
        lstart_nxt   = '0;
        entries_nxt  = '0;
        prev_len_nxt = '0;
        cur_len_nxt  = '0;
        lchars_nxt   = '0;
        if (phase_r == PH_WORD) begin
          res_vld        = 1'b1;
          res.kind       = stib_pkg::KIND_ERROR;
          res.error_code = stib_pkg::ERR_MISSING_TAB;
        end else if (phase_r != PH_ERROR) begin
          res_vld = 1'b1;
          if (entries_r == '0) begin
            res.kind       = stib_pkg::KIND_ERROR;
            res.error_code = stib_pkg::ERR_EMPTY;
          end else begin
            res.kind        = stib_pkg::KIND_DONE;
            res.entry_count = entries_r;
          end
        end
      end else begin
        pos_nxt = pos_r + 32'd1;
        if (phase_r == PH_ERROR) begin
          // drop bytes until end of file
        end else if (b == stib_pkg::CH_LF || b == stib_pkg::CH_CR) begin
          if (b == stib_pkg::CH_LF && cr_r) begin
            cr_nxt = 1'b0;
          end else begin
            cr_nxt = (b == stib_pkg::CH_CR);
            if (phase_r == PH_WORD) begin
              phase_nxt      = PH_ERROR;
              res_vld        = 1'b1;
              res.kind       = stib_pkg::KIND_ERROR;
              res.error_code = stib_pkg::ERR_MISSING_TAB;
            end else begin
              phase_nxt = PH_START;
            end
          end
        end else begin
          cr_nxt = 1'b0;
          if (phase_r != PH_REST) begin
            if (phase_r == PH_START) begin
              phase_nxt  = PH_WORD;
              lstart_nxt = pos_r;
              lchars     = '0;
              clen       = '0;
              ord        = ORD_EQUAL;
            end
            order_nxt = ord;
            if (lchars >= CW'(LINE_LIMIT - 1) || b == stib_pkg::CH_NUL) begin
              phase_nxt      = PH_ERROR;
              res_vld        = 1'b1;
              res.kind       = stib_pkg::KIND_ERROR;
              res.error_code = stib_pkg::ERR_MISSING_TAB;
            end else begin
              lchars_nxt = lchars + CW'(1);
              if (b == stib_pkg::CH_TAB) begin
                if (ord == ORD_EQUAL && clen < prev_len_r) begin
                  ord = ORD_LESS;
                end
                order_nxt = ord;
                res_vld   = 1'b1;
                if (ord == ORD_LESS) begin
                  phase_nxt      = PH_ERROR;
                  res.kind       = stib_pkg::KIND_ERROR;
                  res.error_code = stib_pkg::ERR_SORT_ORDER;
                end else begin
                  if (entries_r != 32'hFFFF_FFFF) begin
                    entries_nxt = entries_r + 32'd1;
                  end
                  prev_len_nxt    = clen;
                  cur_len_nxt     = clen;
                  phase_nxt       = PH_REST;
                  res.kind        = stib_pkg::KIND_ENTRY;
                  res.line_offset = (phase_r == PH_START) ? pos_r : lstart_r;
                  res.word_length = 5'(clen);
                  res.entry_count = entries_nxt;
                end
              end else if (clen >= LW'(WORD_MAX - 1)) begin
                cur_len_nxt = clen;
              end else begin
                if (ord == ORD_EQUAL) begin
                  if (clen >= prev_len_r) begin
                    order_nxt = ORD_GREATER;
                  end else begin
                    pend_nxt   = 1'b1;
                    pend_c_nxt = stib_pkg::fold_case(b);
                  end
                end
                mem_en            = 1'b1;
                mem_addr          = AW'(clen);
                cur_len_nxt       = clen + LW'(1);
                res_vld           = 1'b1;
                res.kind          = stib_pkg::KIND_WORD_BYTE;
                res.word_byte     = b;
                res.char_position = 5'(clen);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      cr_r       <= 1'b0;
      order_r    <= ORD_EQUAL;
      pend_r     <= 1'b0;
      pos_r      <= '0;
      lstart_r   <= '0;
      entries_r  <= '0;
      prev_len_r <= '0;
      cur_len_r  <= '0;
      lchars_r   <= '0;
    end else begin
      phase_r    <= phase_nxt;
      cr_r       <= cr_nxt;
      order_r    <= order_nxt;
      pend_r     <= pend_nxt;
      pos_r      <= pos_nxt;
      lstart_r   <= lstart_nxt;
      entries_r  <= entries_nxt;
      prev_len_r <= prev_len_nxt;
      cur_len_r  <= cur_len_nxt;
      lchars_r   <= lchars_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_c_r <= pend_c_nxt;
  end

  stib_word_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_word_mem (
    .clk   (clk),
    .en    (mem_en),
    .addr  (mem_addr),
    .wdata (in_tdata),
    .rdata (mem_rd)
  );

  stib_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .ready     (buf_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {4'b0000, out_res.error_code, out_res.entry_count,
                      out_res.word_length, out_res.line_offset,
                      out_res.char_position, out_res.word_byte};
  assign out_tuser = out_res.kind;

  a_pend_only_when_equal: assert property (
    @(posedge clk) disable iff (!rst_n)
    pend_r |-> (order_r == ORD_EQUAL)
  ) else $error("pending compare while order already decided");

  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid
  ) else $error("input stalled with empty output");

  a_eof_rearms: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_beat && in_tlast) |=> (phase_r == PH_START && entries_r == '0 && pos_r == '0)
  ) else $error("end of file did not rearm the parser");

  a_word_len_bound: assert property (
    @(posedge clk) disable iff (!rst_n)
    mem_en |-> (cur_len_r < LW'(WORD_MAX - 1) || phase_r == PH_START)
  ) else $error("word memory write beyond stored word length");

endmodule
